@@ src/fwpsc_pkg.sv @@
// shared types and constants for the four wheel pi speed controller
// holds field widths, register map, microcode control word and the program rom
// no dependencies
package fwpsc_pkg;

  localparam int WHEELS      = 4;
  localparam int WHEEL_IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int SPEED_BITS  = 16;
  localparam int INTEG_BITS  = 48;

  // datapath widths
  localparam int ERR_W   = SPEED_BITS + 8;
  localparam int INC_W   = ERR_W + 16;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PTERM_W = ERR_W + 24;
  localparam int Q_W     = PROD_W;
  localparam int V_W     = Q_W + 2;
  localparam int VMAG_W  = 32;
  localparam int DRIVE_W = 16;
  localparam int DRIVE_MAX = 25600;

  // register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GEAR_RATIO = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_TIME  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_LIMIT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_SCALE  = 3'd5;

  localparam logic [23:0] PROP_GAIN_RST  = 24'd53646;
  localparam logic [23:0] INTEG_GAIN_RST = 24'd11301496;
  localparam logic [7:0]  GEAR_RATIO_RST = 8'd19;
  localparam logic [15:0] STEP_TIME_RST  = 16'd655;
  localparam logic [23:0] VOLT_LIMIT_RST = 24'd1415578;
  localparam logic [23:0] OUT_SCALE_RST  = 24'd303407;

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    A_DIFF, A_ERR, A_HI, A_LO, A_VMAG
  } a_sel_t;

  typedef enum logic [2:0] {
    B_GEAR, B_STEP, B_PROP, B_INTEG, B_OSCALE
  } b_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DIFF, OP_ERR, OP_INTEG, OP_AMAG, OP_PTERM,
    OP_QHI, OP_QLO, OP_SUM, OP_CLAMP, OP_DRIVE
  } op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WHEEL, SEQ_FINISH
  } seq_t;

  typedef struct packed {
    logic   mul_en;
    a_sel_t a_sel;
    b_sel_t b_sel;
    op_t    op;
    seq_t   seq;
  } ctrl_t;

  // per wheel program; the shared multiplier result is registered in prod before a later step reads it
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{mul_en: 1'b0, a_sel: A_DIFF, b_sel: B_GEAR, op: OP_NONE, seq: SEQ_NEXT};
    unique case (pc)
      4'd0:  c.op = OP_DIFF;
      4'd1:  begin c.mul_en = 1'b1; c.a_sel = A_DIFF; c.b_sel = B_GEAR; end
      4'd2:  c.op = OP_ERR;
      4'd3:  begin c.mul_en = 1'b1; c.a_sel = A_ERR; c.b_sel = B_STEP; end
      4'd4:  c.op = OP_INTEG;
      4'd5:  begin
        c.mul_en = 1'b1; c.a_sel = A_ERR; c.b_sel = B_PROP; c.op = OP_AMAG;
      end
      4'd6:  begin
        c.mul_en = 1'b1; c.a_sel = A_HI; c.b_sel = B_INTEG; c.op = OP_PTERM;
      end
      4'd7:  begin
        c.mul_en = 1'b1; c.a_sel = A_LO; c.b_sel = B_INTEG; c.op = OP_QHI;
      end
      4'd8:  c.op = OP_QLO;
      4'd9:  c.op = OP_SUM;
      4'd10: c.op = OP_CLAMP;
      4'd11: begin c.mul_en = 1'b1; c.a_sel = A_VMAG; c.b_sel = B_OSCALE; end
      4'd12: begin c.op = OP_DRIVE; c.seq = SEQ_WHEEL; end
      4'd13: c.seq = SEQ_FINISH;
      default: c.seq = SEQ_FINISH;
    endcase
    return c;
  endfunction

endpackage

@@ src/four_wheel_pi_speed_control.sv @@
// four wheel pi speed controller: microcoded sequencer over one shared 32x24 multiplier
// each request runs 13 program steps per wheel over 4 wheels, then one finish step; a new
// request is not taken until the finish step, as the shared multiplier is sequenced by
// the per wheel program; a finished result may wait in the output register
// synchronous active low reset clears integrators, control and loads register defaults
// depends on fwpsc_pkg
module four_wheel_pi_speed_control
  import fwpsc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SPEED_BITS-1:0] in_ref_speed_a,
  input  logic signed [SPEED_BITS-1:0] in_ref_speed_b,
  input  logic signed [SPEED_BITS-1:0] in_ref_speed_c,
  input  logic signed [SPEED_BITS-1:0] in_ref_speed_d,
  input  logic signed [SPEED_BITS-1:0] in_meas_speed_a,
  input  logic signed [SPEED_BITS-1:0] in_meas_speed_b,
  input  logic signed [SPEED_BITS-1:0] in_meas_speed_c,
  input  logic signed [SPEED_BITS-1:0] in_meas_speed_d,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DRIVE_W-1:0]    out_drive_a,
  output logic signed [DRIVE_W-1:0]    out_drive_b,
  output logic signed [DRIVE_W-1:0]    out_drive_c,
  output logic signed [DRIVE_W-1:0]    out_drive_d
);

  // configuration registers
  logic [23:0] prop_gain_r, integ_gain_r, volt_limit_r, out_scale_r;
  logic [7:0]  gear_ratio_r;
  logic [15:0] step_time_r;

  // control
  logic                   busy_r, out_valid_r;
  logic [PC_W-1:0]        pc_r;
  logic [WHEEL_IDX_W-1:0] wheel_r;
  ctrl_t                  ctrl;
  logic                   in_take, cfg_wr, fin_go;

  // datapath
  logic [SPEED_BITS-1:0] ref_r  [WHEELS];
  logic [SPEED_BITS-1:0] meas_r [WHEELS];
  logic [INTEG_BITS-1:0] integ_r [WHEELS];
  logic [DRIVE_W-1:0]    drive_r [WHEELS];
  logic [DRIVE_W-1:0]    out_drive_r [WHEELS];
  logic [PROD_W-1:0]     prod_r;
  logic [SPEED_BITS-1:0] diff_mag_r;
  logic                  diff_neg_r;
  logic [ERR_W-1:0]      err_mag_r;
  logic                  err_neg_r;
  logic [INTEG_BITS-1:0] acc_mag_r;
  logic                  acc_neg_r;
  logic [PTERM_W:0]      p_r;
  logic [Q_W-1:0]        q_r;
  logic [V_W-1:0]        v_r;
  logic [VMAG_W-1:0]     vmag_r;
  logic                  vneg_r;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod_nxt;
  logic [SPEED_BITS-1:0] cur_ref, cur_meas;
  logic [INTEG_BITS-1:0] cur_integ;
  logic [SPEED_BITS:0]   diff_s, diff_abs;
  logic [INC_W:0]        inc_s;
  logic [INTEG_BITS:0]   acc_sum;
  logic [INTEG_BITS-1:0] acc_sat, acc_abs;
  logic [PTERM_W:0]      p_signed;
  logic [Q_W-1:0]        q_add;
  logic [V_W-1:0]        p_ext, q_ext, v_sum, lim_ext, v_abs;
  logic                  v_gt, v_lt;
  logic [PROD_W:0]       rnd;
  logic [PROD_W-32:0]    dmag;
  logic [DRIVE_W-1:0]    dsat, drive_val;

  assign pready    = 1'b1;
  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign in_take   = in_valid && !busy_r;
  assign cfg_wr    = psel && penable && pwrite;
  assign ctrl      = ucode(pc_r);
  assign fin_go    = busy_r && (ctrl.seq == SEQ_FINISH) && (!out_valid_r || !out_stall);

  assign out_drive_a = out_drive_r[0];
  assign out_drive_b = out_drive_r[1];
  assign out_drive_c = out_drive_r[2];
  assign out_drive_d = out_drive_r[3];

  // config read
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_PROP_GAIN:  prdata = {8'd0, prop_gain_r};
      REG_INTEG_GAIN: prdata = {8'd0, integ_gain_r};
      REG_GEAR_RATIO: prdata = {24'd0, gear_ratio_r};
      REG_STEP_TIME:  prdata = {16'd0, step_time_r};
      REG_VOLT_LIMIT: prdata = {8'd0, volt_limit_r};
      REG_OUT_SCALE:  prdata = {8'd0, out_scale_r};
      default:        prdata = 32'd0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.a_sel)
      A_DIFF:  mul_a = {{(MUL_A_W-SPEED_BITS){1'b0}}, diff_mag_r};
      A_ERR:   mul_a = {{(MUL_A_W-ERR_W){1'b0}}, err_mag_r};
      A_HI:    mul_a = acc_mag_r[INTEG_BITS-1:16];
      A_LO:    mul_a = {{(MUL_A_W-16){1'b0}}, acc_mag_r[15:0]};
      A_VMAG:  mul_a = vmag_r;
      default: mul_a = '0;
    endcase
    unique case (ctrl.b_sel)
      B_GEAR:   mul_b = {16'd0, gear_ratio_r};
      B_STEP:   mul_b = {8'd0, step_time_r};
      B_PROP:   mul_b = prop_gain_r;
      B_INTEG:  mul_b = integ_gain_r;
      B_OSCALE: mul_b = out_scale_r;
      default:  mul_b = '0;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // step datapath
  always_comb begin
    cur_ref   = ref_r[wheel_r];
    cur_meas  = meas_r[wheel_r];
    cur_integ = integ_r[wheel_r];

    diff_s   = {cur_ref[SPEED_BITS-1], cur_ref} - {cur_meas[SPEED_BITS-1], cur_meas};
    diff_abs = diff_s[SPEED_BITS] ? ((SPEED_BITS+1)'(0) - diff_s) : diff_s;

    // integrator increment carries the error sign
    inc_s   = err_neg_r ? ((INC_W+1)'(0) - {1'b0, prod_r[INC_W-1:0]})
                        : {1'b0, prod_r[INC_W-1:0]};
    acc_sum = {cur_integ[INTEG_BITS-1], cur_integ}
            + {{(INTEG_BITS-INC_W){inc_s[INC_W]}}, inc_s};
    if (acc_sum[INTEG_BITS] != acc_sum[INTEG_BITS-1])
      acc_sat = acc_sum[INTEG_BITS] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                    : {1'b0, {(INTEG_BITS-1){1'b1}}};
    else
      acc_sat = acc_sum[INTEG_BITS-1:0];
    acc_abs = cur_integ[INTEG_BITS-1] ? (INTEG_BITS'(0) - cur_integ) : cur_integ;

    p_signed = err_neg_r ? ((PTERM_W+1)'(0) - {1'b0, prod_r[PTERM_W-1:0]})
                         : {1'b0, prod_r[PTERM_W-1:0]};
    q_add    = q_r + {16'd0, prod_r[PROD_W-1:16]};

    p_ext = {{(V_W-PTERM_W-1){p_r[PTERM_W]}}, p_r};
    q_ext = {2'b00, q_r};
    v_sum = acc_neg_r ? (p_ext - q_ext) : (p_ext + q_ext);

    // symmetric clamp on the voltage command
    lim_ext = {{(V_W-32){1'b0}}, volt_limit_r, 8'd0};
    v_abs   = v_r[V_W-1] ? (V_W'(0) - v_r) : v_r;
    v_gt    = !v_r[V_W-1] && (v_r > lim_ext);
    v_lt    = v_r[V_W-1] && (v_abs > lim_ext);

    // round half away from zero on the magnitude
    rnd       = {1'b0, prod_r} + ((PROD_W+1)'(1) << 31);
    dmag      = rnd[PROD_W:32];
    dsat      = (dmag > (PROD_W-31)'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX) : dmag[DRIVE_W-1:0];
    drive_val = vneg_r ? (DRIVE_W'(0) - dsat) : dsat;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      wheel_r     <= '0;
    end else begin
      if (fin_go)
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
      if (!busy_r) begin
        if (in_valid) begin
          busy_r  <= 1'b1;
          pc_r    <= '0;
          wheel_r <= '0;
        end
      end else begin
        unique case (ctrl.seq)
          SEQ_NEXT: pc_r <= pc_r + PC_W'(1);
          SEQ_WHEEL: begin
            if (wheel_r == WHEEL_IDX_W'(WHEELS-1)) begin
              pc_r <= pc_r + PC_W'(1);
            end else begin
              pc_r    <= '0;
              wheel_r <= wheel_r + WHEEL_IDX_W'(1);
            end
          end
          SEQ_FINISH: begin
            if (fin_go)
              busy_r <= 1'b0;
          end
          default: pc_r <= pc_r;
        endcase
      end
    end
  end

  // configuration and integrator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      gear_ratio_r <= GEAR_RATIO_RST;
      step_time_r  <= STEP_TIME_RST;
      volt_limit_r <= VOLT_LIMIT_RST;
      out_scale_r  <= OUT_SCALE_RST;
      for (int w = 0; w < WHEELS; w++)
        integ_r[w] <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[ADDR_W-1:2])
          REG_PROP_GAIN:  prop_gain_r  <= pwdata[23:0];
          REG_INTEG_GAIN: integ_gain_r <= pwdata[23:0];
          REG_GEAR_RATIO: gear_ratio_r <= pwdata[7:0];
          REG_STEP_TIME:  step_time_r  <= pwdata[15:0];
          REG_VOLT_LIMIT: volt_limit_r <= pwdata[23:0];
          REG_OUT_SCALE:  out_scale_r  <= pwdata[23:0];
          default: ;
        endcase
      end
      if (busy_r && ctrl.op == OP_INTEG)
        integ_r[wheel_r] <= acc_sat;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      ref_r[0]  <= in_ref_speed_a;
      ref_r[1]  <= in_ref_speed_b;
      ref_r[2]  <= in_ref_speed_c;
      ref_r[3]  <= in_ref_speed_d;
      meas_r[0] <= in_meas_speed_a;
      meas_r[1] <= in_meas_speed_b;
      meas_r[2] <= in_meas_speed_c;
      meas_r[3] <= in_meas_speed_d;
    end
    if (busy_r && ctrl.mul_en)
      prod_r <= prod_nxt;
    if (busy_r) begin
      unique case (ctrl.op)
        OP_NONE: ;
        OP_DIFF: begin
          diff_mag_r <= diff_abs[SPEED_BITS-1:0];
          diff_neg_r <= diff_s[SPEED_BITS];
        end
        OP_ERR: begin
          err_mag_r <= prod_r[ERR_W-1:0];
          err_neg_r <= diff_neg_r && (|prod_r[ERR_W-1:0]);
        end
        OP_INTEG: ;
        OP_AMAG: begin
          acc_mag_r <= acc_abs;
          acc_neg_r <= cur_integ[INTEG_BITS-1];
        end
        OP_PTERM: p_r <= p_signed;
        OP_QHI:   q_r <= prod_r[Q_W-1:0];
        OP_QLO:   q_r <= q_add;
        OP_SUM:   v_r <= v_sum;
        OP_CLAMP: begin
          if (v_gt) begin
            vmag_r <= lim_ext[VMAG_W-1:0];
            vneg_r <= 1'b0;
          end else if (v_lt) begin
            vmag_r <= lim_ext[VMAG_W-1:0];
            vneg_r <= 1'b1;
          end else begin
            vmag_r <= v_abs[VMAG_W-1:0];
            vneg_r <= v_r[V_W-1];
          end
        end
        OP_DRIVE: drive_r[wheel_r] <= drive_val;
        default: ;
      endcase
    end
    if (fin_go) begin
      for (int w = 0; w < WHEELS; w++)
        out_drive_r[w] <= drive_r[w];
    end
  end

endmodule

@@ src/fwpsc_chk.sv @@
// port level checks for the four wheel pi speed controller, bound to the top level
// depends on fwpsc_pkg and four_wheel_pi_speed_control
module fwpsc_chk
  import fwpsc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DRIVE_W-1:0] out_drive_a,
  input logic signed [DRIVE_W-1:0] out_drive_b,
  input logic signed [DRIVE_W-1:0] out_drive_c,
  input logic signed [DRIVE_W-1:0] out_drive_d
);

  // a taken request blocks the next one
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // a result only appears at the end of a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // drive commands stay within plus or minus full scale
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_a >= -DRIVE_MAX) && (out_drive_a <= DRIVE_MAX)
               && (out_drive_b >= -DRIVE_MAX) && (out_drive_b <= DRIVE_MAX)
               && (out_drive_c >= -DRIVE_MAX) && (out_drive_c <= DRIVE_MAX)
               && (out_drive_d >= -DRIVE_MAX) && (out_drive_d <= DRIVE_MAX))
    else $error("drive command out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_a) && $stable(out_drive_b)
                               && $stable(out_drive_c) && $stable(out_drive_d))
    else $error("stalled result changed");

endmodule

bind four_wheel_pi_speed_control fwpsc_chk u_fwpsc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_drive_a (out_drive_a),
  .out_drive_b (out_drive_b),
  .out_drive_c (out_drive_c),
  .out_drive_d (out_drive_d)
);
